// ===== hw/rtl/eof_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eof_pkg
// Shared types and widths of the ellipse obstacle filter.
// ----------------------------------------------------------------------------
package eof_pkg;

    localparam int COORD_W   = 32;              // signed Q15.16 coordinate
    localparam int AXIS_W    = 31;              // unsigned Q15.16 half-axis
    localparam int CFG_IDX_W = 1;
    localparam int IDX_W     = 8;               // compacted kept index
    localparam int CNT_W     = 9;               // saturating counts
    localparam int KEPT_MAX  = 2 ** IDX_W;      // counts never pass this

    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

    // One classified time step, as it waits between front and back.
    typedef struct packed {
        logic               frame;      // clear counts before this step
        logic               first;      // first step of its obstacle
        logic               low_cmp;    // half_axis_z below the height limit
        logic               last;       // last step: issue a result
        logic               nz;         // both widened half-axes nonzero
        logic [COORD_W-1:0] dx;         // |point_x - obstacle_x|
        logic [COORD_W-1:0] dy;         // |point_y - obstacle_y|
        logic [COORD_W-1:0] ax;         // half_axis_x + margin
        logic [COORD_W-1:0] by;         // half_axis_y + margin
    } t_item;

endpackage

// ===== hw/rtl/eof_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eof_front
// Accepts input words, holds the configuration registers and classifies each
// step: absolute distances, widened half-axes, first/last and height flags.
// ----------------------------------------------------------------------------
module eof_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [eof_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [eof_pkg::COORD_W-1:0]     i_cfg_data,
    input  logic                            i_valid,
    input  logic                            i_frame_start,
    input  logic [eof_pkg::COORD_W-1:0]     i_obstacle_x,
    input  logic [eof_pkg::COORD_W-1:0]     i_obstacle_y,
    input  logic [eof_pkg::AXIS_W-1:0]      i_half_axis_x,
    input  logic [eof_pkg::AXIS_W-1:0]      i_half_axis_y,
    input  logic [eof_pkg::COORD_W-1:0]     i_half_axis_z,
    input  logic [eof_pkg::COORD_W-1:0]     i_point_x,
    input  logic [eof_pkg::COORD_W-1:0]     i_point_y,
    input  logic                            i_last_step,
    input  logic                            i_full,
    output logic                            o_push,
    output eof_pkg::t_item                  o_item
);
    import eof_pkg::*;

    logic [AXIS_W-1:0]  r_margin;
    logic [COORD_W-1:0] r_height_limit;
    logic               r_at_first;
    logic               n_at_first;

    logic [COORD_W:0]   w_dx_pos;
    logic [COORD_W:0]   w_dx_neg;
    logic [COORD_W:0]   w_dy_pos;
    logic [COORD_W:0]   w_dy_neg;

    assign o_push = i_valid && !i_full;

    // Both subtraction orders in parallel; the sign picks the positive one.
    assign w_dx_pos = {i_point_x[COORD_W-1], i_point_x}
                    - {i_obstacle_x[COORD_W-1], i_obstacle_x};
    assign w_dx_neg = {i_obstacle_x[COORD_W-1], i_obstacle_x}
                    - {i_point_x[COORD_W-1], i_point_x};
    assign w_dy_pos = {i_point_y[COORD_W-1], i_point_y}
                    - {i_obstacle_y[COORD_W-1], i_obstacle_y};
    assign w_dy_neg = {i_obstacle_y[COORD_W-1], i_obstacle_y}
                    - {i_point_y[COORD_W-1], i_point_y};

    always_comb begin
        o_item.frame   = i_frame_start;
        o_item.first   = i_frame_start || r_at_first;
        o_item.low_cmp = $signed(i_half_axis_z) < $signed(r_height_limit);
        o_item.last    = i_last_step;
        o_item.dx      = w_dx_pos[COORD_W] ? w_dx_neg[COORD_W-1:0] : w_dx_pos[COORD_W-1:0];
        o_item.dy      = w_dy_pos[COORD_W] ? w_dy_neg[COORD_W-1:0] : w_dy_pos[COORD_W-1:0];
        o_item.ax      = {1'b0, i_half_axis_x} + {1'b0, r_margin};
        o_item.by      = {1'b0, i_half_axis_y} + {1'b0, r_margin};
        o_item.nz      = (o_item.ax != '0) && (o_item.by != '0);
    end

    always_comb begin
        n_at_first = r_at_first;
        if (o_push) begin
            n_at_first = i_last_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin       <= '0;
            r_height_limit <= '0;
            r_at_first     <= 1'b1;
        end else begin
            r_at_first <= n_at_first;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MARGIN: r_margin       <= i_cfg_data[AXIS_W-1:0];
                    CFG_HEIGHT: r_height_limit <= i_cfg_data;
                    default:    ;
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/eof_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eof_queue
// Two-entry queue of classified steps between front and back.
// ----------------------------------------------------------------------------
module eof_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  eof_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output eof_pkg::t_item  o_head
);
    import eof_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [PTR_W:0]     r_cnt;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic [PTR_W:0]     n_cnt;

    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/eof_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eof_back
// Cross-multiplied ellipse test on three shared 32x32 multipliers, the hit
// accumulation per obstacle, running counts and the result register.
// ----------------------------------------------------------------------------
module eof_back #(
    parameter int MAX_OBSTACLES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_head_valid,
    input  eof_pkg::t_item                  i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_kept,
    output logic                            o_low_obstacle,
    output logic [eof_pkg::IDX_W-1:0]       o_kept_index,
    output logic [eof_pkg::CNT_W-1:0]       o_kept_count,
    output logic [eof_pkg::CNT_W-1:0]       o_low_count
);
    import eof_pkg::*;

    localparam int CAP_INT = (MAX_OBSTACLES > KEPT_MAX) ? KEPT_MAX : MAX_OBSTACLES;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAP_INT);
    localparam logic [CNT_W-1:0] IDX_TOP = CNT_W'(KEPT_MAX - 1);

    localparam int PROD_W = 2 * COORD_W;
    localparam int SUM_W  = 2 * PROD_W + 1;
    localparam int SQ_W   = 2 * PROD_W;

    // Multiplier phases: load u, v, w; then low, cross and high halves.
    localparam logic [1:0] PH_LOAD  = 2'd0;
    localparam logic [1:0] PH_LO    = 2'd1;
    localparam logic [1:0] PH_CROSS = 2'd2;
    localparam logic [1:0] PH_HI    = 2'd3;

    // What the partial product registers hold.
    localparam logic [1:0] K_NONE  = 2'd0;
    localparam logic [1:0] K_LO    = 2'd1;
    localparam logic [1:0] K_CROSS = 2'd2;
    localparam logic [1:0] K_HI    = 2'd3;

    typedef struct packed {
        logic frame;
        logic first;
        logic low_cmp;
        logic last;
        logic nz;
    } t_side;

    logic               w_adv;
    logic [1:0]         r_ph;
    logic [1:0]         n_ph;
    logic [1:0]         r_pk;
    logic [1:0]         n_pk;
    logic               r_cv;
    logic               n_cv;

    logic [PROD_W-1:0]  r_u;
    logic [PROD_W-1:0]  r_v;
    logic [PROD_W-1:0]  r_w;
    t_side              r_side;
    t_side              r_cside;
    logic [PROD_W-1:0]  r_pu;
    logic [PROD_W-1:0]  r_pv;
    logic [PROD_W-1:0]  r_pw;
    logic [SUM_W-1:0]   r_s;
    logic [SQ_W-1:0]    r_w2;

    logic [COORD_W-1:0] w_a0, w_b0, w_a1, w_b1, w_a2, w_b2;
    logic [PROD_W-1:0]  w_m0, w_m1, w_m2;

    logic               r_hit;
    logic               r_first_low;
    logic [CNT_W-1:0]   r_kept_cnt;
    logic [CNT_W-1:0]   r_low_cnt;
    logic               n_hit;
    logic               n_first_low;
    logic [CNT_W-1:0]   n_kept_cnt;
    logic [CNT_W-1:0]   n_low_cnt;

    logic               w_inside;
    logic               w_hit;
    logic               w_low_eff;
    logic [CNT_W-1:0]   w_kc;
    logic [CNT_W-1:0]   w_lc;
    logic               w_kept;
    logic               w_low;
    logic [IDX_W-1:0]   w_idx;
    logic               w_emit;

    logic               r_ov;
    logic               n_ov;

    // The whole back end freezes while a finished word waits on a stall.
    assign w_adv = !r_ov || !i_stall;
    assign o_pop = w_adv && (r_ph == PH_LOAD) && i_head_valid;

    always_comb begin
        case (r_ph)
            PH_LO: begin
                w_a0 = r_u[COORD_W-1:0];  w_b0 = r_u[COORD_W-1:0];
                w_a1 = r_v[COORD_W-1:0];  w_b1 = r_v[COORD_W-1:0];
                w_a2 = r_w[COORD_W-1:0];  w_b2 = r_w[COORD_W-1:0];
            end
            PH_CROSS: begin
                w_a0 = r_u[COORD_W-1:0];  w_b0 = r_u[PROD_W-1:COORD_W];
                w_a1 = r_v[COORD_W-1:0];  w_b1 = r_v[PROD_W-1:COORD_W];
                w_a2 = r_w[COORD_W-1:0];  w_b2 = r_w[PROD_W-1:COORD_W];
            end
            PH_HI: begin
                w_a0 = r_u[PROD_W-1:COORD_W];  w_b0 = r_u[PROD_W-1:COORD_W];
                w_a1 = r_v[PROD_W-1:COORD_W];  w_b1 = r_v[PROD_W-1:COORD_W];
                w_a2 = r_w[PROD_W-1:COORD_W];  w_b2 = r_w[PROD_W-1:COORD_W];
            end
            default: begin
                w_a0 = i_head.dx;  w_b0 = i_head.by;
                w_a1 = i_head.dy;  w_b1 = i_head.ax;
                w_a2 = i_head.ax;  w_b2 = i_head.by;
            end
        endcase
    end

    assign w_m0 = w_a0 * w_b0;
    assign w_m1 = w_a1 * w_b1;
    assign w_m2 = w_a2 * w_b2;

    always_comb begin
        n_ph = r_ph;
        n_pk = r_pk;
        n_cv = r_cv;
        if (w_adv) begin
            case (r_ph)
                PH_LOAD:  n_ph = o_pop ? PH_LO : PH_LOAD;
                PH_LO:    n_ph = PH_CROSS;
                PH_CROSS: n_ph = PH_HI;
                default:  n_ph = PH_LOAD;
            endcase
            case (r_ph)
                PH_LO:    n_pk = K_LO;
                PH_CROSS: n_pk = K_CROSS;
                PH_HI:    n_pk = K_HI;
                default:  n_pk = K_NONE;
            endcase
            n_cv = (r_pk == K_HI);
        end
    end

    // Ellipse test and per-obstacle bookkeeping.
    always_comb begin
        w_inside  = r_cside.nz && (r_s <= {1'b0, r_w2});
        w_hit     = (r_cside.frame ? 1'b0 : r_hit) || w_inside;
        w_low_eff = r_cside.first ? r_cside.low_cmp : r_first_low;
        w_kc      = r_cside.frame ? '0 : r_kept_cnt;
        w_lc      = r_cside.frame ? '0 : r_low_cnt;
        w_kept    = w_hit;
        w_low     = w_hit && w_low_eff;
        w_idx     = '0;
        if (w_kept) begin
            w_idx = (w_kc > IDX_TOP) ? IDX_TOP[IDX_W-1:0] : w_kc[IDX_W-1:0];
        end
        w_emit      = w_adv && r_cv && r_cside.last;
        n_hit       = r_hit;
        n_first_low = r_first_low;
        n_kept_cnt  = r_kept_cnt;
        n_low_cnt   = r_low_cnt;
        if (w_adv && r_cv) begin
            n_kept_cnt = w_kc;
            n_low_cnt  = w_lc;
            if (r_cside.last) begin
                n_hit       = 1'b0;
                n_first_low = 1'b0;
                if (w_kept && (w_kc < CAP)) begin
                    n_kept_cnt = w_kc + 1'b1;
                end
                if (w_low && (w_lc < CAP)) begin
                    n_low_cnt = w_lc + 1'b1;
                end
            end else begin
                n_hit       = w_hit;
                n_first_low = w_low_eff;
            end
        end
        n_ov = (r_ov && i_stall) || w_emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph        <= PH_LOAD;
            r_pk        <= K_NONE;
            r_cv        <= 1'b0;
            r_hit       <= 1'b0;
            r_first_low <= 1'b0;
            r_kept_cnt  <= '0;
            r_low_cnt   <= '0;
            r_ov        <= 1'b0;
        end else begin
            r_ph        <= n_ph;
            r_pk        <= n_pk;
            r_cv        <= n_cv;
            r_hit       <= n_hit;
            r_first_low <= n_first_low;
            r_kept_cnt  <= n_kept_cnt;
            r_low_cnt   <= n_low_cnt;
            r_ov        <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_u    <= w_m0;
            r_v    <= w_m1;
            r_w    <= w_m2;
            r_side <= '{frame: i_head.frame, first: i_head.first,
                        low_cmp: i_head.low_cmp, last: i_head.last, nz: i_head.nz};
        end
        if (w_adv) begin
            r_pu <= w_m0;
            r_pv <= w_m1;
            r_pw <= w_m2;
            case (r_pk)
                K_LO: begin
                    r_s  <= SUM_W'(r_pu) + SUM_W'(r_pv);
                    r_w2 <= SQ_W'(r_pw);
                end
                K_CROSS: begin
                    // cross term counts twice: shift by one past the half width
                    r_s  <= r_s + (SUM_W'(r_pu) << (COORD_W + 1))
                                + (SUM_W'(r_pv) << (COORD_W + 1));
                    r_w2 <= r_w2 + (SQ_W'(r_pw) << (COORD_W + 1));
                end
                K_HI: begin
                    r_s     <= r_s + (SUM_W'(r_pu) << PROD_W) + (SUM_W'(r_pv) << PROD_W);
                    r_w2    <= r_w2 + (SQ_W'(r_pw) << PROD_W);
                    r_cside <= r_side;
                end
                default: ;
            endcase
        end
        if (w_emit) begin
            o_kept         <= w_kept;
            o_low_obstacle <= w_low;
            o_kept_index   <= w_idx;
            o_kept_count   <= n_kept_cnt;
            o_low_count    <= n_low_cnt;
        end
    end

    assign o_valid = r_ov;

endmodule

// ===== hw/rtl/ellipse_obstacle_filter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ellipse_obstacle_filter_core
// Proximity culling of obstacles against a trajectory by an exact
// cross-multiplied ellipse test, with per-obstacle results and counts.
//
//   Channel   Direction  Handshake               Word
//   in        sink       i_in_valid / o_in_stall  one time step of one obstacle
//   out       source     o_out_valid / i_out_stall one result per last step
//   cfg       sink       i_cfg_we                 margin, height limit
//
// In the back end one phase sequencer drives three shared 32x32 multipliers
// (u, v, w products, then low, cross and high halves of their squares) and
// takes the next step from the queue only after the high-half phase of the
// last one.
// A two-entry queue lets the front keep accepting while the back works.
// Reset is synchronous, active low; counts and flags clear, config goes to 0.
// A stalled result word freezes the back end until it is taken.
// ----------------------------------------------------------------------------
module ellipse_obstacle_filter_core #(
    parameter int MAX_OBSTACLES = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [eof_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [eof_pkg::COORD_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_frame_start,
    input  logic [eof_pkg::COORD_W-1:0]     i_obstacle_x,
    input  logic [eof_pkg::COORD_W-1:0]     i_obstacle_y,
    input  logic [eof_pkg::AXIS_W-1:0]      i_half_axis_x,
    input  logic [eof_pkg::AXIS_W-1:0]      i_half_axis_y,
    input  logic [eof_pkg::COORD_W-1:0]     i_half_axis_z,
    input  logic [eof_pkg::COORD_W-1:0]     i_point_x,
    input  logic [eof_pkg::COORD_W-1:0]     i_point_y,
    input  logic                            i_last_step,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_kept,
    output logic                            o_low_obstacle,
    output logic [eof_pkg::IDX_W-1:0]       o_kept_index,
    output logic [eof_pkg::CNT_W-1:0]       o_kept_count,
    output logic [eof_pkg::CNT_W-1:0]       o_low_count
);
    import eof_pkg::*;

    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_head_valid;
    t_item  w_item;
    t_item  w_head;

    assign o_in_stall = w_full;

    eof_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_in_valid),
        .i_frame_start (i_frame_start),
        .i_obstacle_x  (i_obstacle_x),
        .i_obstacle_y  (i_obstacle_y),
        .i_half_axis_x (i_half_axis_x),
        .i_half_axis_y (i_half_axis_y),
        .i_half_axis_z (i_half_axis_z),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_last_step   (i_last_step),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_item        (w_item)
    );

    eof_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    eof_back #(
        .MAX_OBSTACLES (MAX_OBSTACLES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (w_head_valid),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_valid        (o_out_valid),
        .i_stall        (i_out_stall),
        .o_kept         (o_kept),
        .o_low_obstacle (o_low_obstacle),
        .o_kept_index   (o_kept_index),
        .o_kept_count   (o_kept_count),
        .o_low_count    (o_low_count)
    );

endmodule
